>>> sv/assert_macros.svh
// Assertion helpers; empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LCB_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define LCB_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define LCB_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define LCB_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

>>> sv/lcbwt_pkg.sv
`timescale 1ns / 1ps
package lcbwt_pkg;
  localparam int MAX_BLOCK = 1024;
  localparam int ADDR_W    = $clog2(MAX_BLOCK);
  localparam int LEN_W     = ADDR_W + 1;
  localparam int PASS_W    = $clog2(MAX_BLOCK / 4 + 3);
  localparam int HIST_D    = 256;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  // clamp to [8, MAX_BLOCK], multiple of four
  function automatic logic [LEN_W-1:0] limit_len(input logic [10:0] v);
    logic [LEN_W-1:0] r;
    if (32'(v) > MAX_BLOCK) r = LEN_W'(MAX_BLOCK);
    else r = LEN_W'(v);
    r[1:0] = 2'b00;
    if (r < LEN_W'(8)) r = LEN_W'(8);
    return r;
  endfunction
endpackage

>>> sv/lcbwt_if.sv
`timescale 1ns / 1ps
interface lcbwt_in_if import lcbwt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  modport source (output valid, opcode, data_byte, input ready);
  modport sink   (input valid, opcode, data_byte, output ready);
endinterface

interface lcbwt_out_if import lcbwt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        out_byte;
  logic [ADDR_W-1:0] prim_idx;
  logic              out_last;
  logic              out_ready;
  modport source (output valid, out_byte, prim_idx, out_last, out_ready, input ready);
  modport sink   (input valid, out_byte, prim_idx, out_last, out_ready, output ready);
endinterface

interface lcbwt_cfg_if ();
  logic        valid;
  logic        ready;
  logic [10:0] block_len;
  modport source (output valid, block_len, input ready);
  modport sink   (input valid, block_len, output ready);
endinterface

>>> sv/lcbwt_ram.sv
`timescale 1ns / 1ps
module lcbwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> sv/limited_context_bwt_sorter_top.sv
`timescale 1ns / 1ps
// Limited-context BWT block sorter.
// in_chan beats: opcode 0 loads the next source byte of a block, opcode 1
// fetches the next transformed byte. Each fetch beat yields one out_chan beat
// (byte, primary index, last flag, ready flag); loads yield none.
// cfg_chan sets block_len (clamped to 8..1024, multiple of four); it is latched
// by the first load of a block.
// After the final load of a block the block runs an LSD radix sort with one
// histogram RAM and ping-pong row buffers, driven by a single sequencer,
// over k = n/4+2 context passes. Each row passes a read chain (row, byte,
// count, write back) through registered RAM ports. A fetch result is valid
// after a row read, a byte read and the output register.
// in_chan.ready is low while sorting, while a fetch is in flight, and while
// a result beat waits on a stalled receiver; nothing is lost on a stall.
// Reset clears all control state; no sorted block exists until one is loaded.
module limited_context_bwt_sorter_top import lcbwt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lcbwt_in_if.sink    in_chan,
  lcbwt_out_if.source out_chan,
  lcbwt_cfg_if.sink   cfg_chan
);
`include "assert_macros.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_INIT, ST_CLR,
    ST_CRD, ST_CST, ST_CHR, ST_CWR,
    ST_PRD, ST_PWR,
    ST_SRD, ST_SST, ST_SHR, ST_SWR,
    ST_FRD, ST_FST, ST_FOUT
  } state_t;

  state_t            state_r;
  logic [10:0]       blen_r;
  logic [LEN_W-1:0]  cur_len_r, load_cnt_r, idx_r;
  logic [ADDR_W-1:0] fetch_cnt_r, prim_r, p_r;
  logic              sorted_r, sel_r;
  logic [PASS_W-1:0] pass_r;
  logic [7:0]        b_r;
  logic [LEN_W-1:0]  sum_r;
  logic              ov_r, oready_r, olast_r;
  logic [7:0]        obyte_r;
  logic [ADDR_W-1:0] oprim_r;

  // memories
  logic              st_we, ra_we, rb_we, h_we;
  logic [ADDR_W-1:0] st_waddr, st_raddr, row_waddr, row_raddr;
  logic [7:0]        st_wdata, st_rdata, h_addr_w, h_raddr;
  logic [ADDR_W-1:0] row_wdata, ra_rdata, rb_rdata, row_rd;
  logic [LEN_W-1:0]  h_wdata, h_rdata;

  lcbwt_ram #(.WIDTH(8), .DEPTH(MAX_BLOCK)) u_store (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata), .raddr(st_raddr), .rdata(st_rdata));
  lcbwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCK)) u_row_a (
    .clk, .we(ra_we), .waddr(row_waddr), .wdata(row_wdata), .raddr(row_raddr),
    .rdata(ra_rdata));
  lcbwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCK)) u_row_b (
    .clk, .we(rb_we), .waddr(row_waddr), .wdata(row_wdata), .raddr(row_raddr),
    .rdata(rb_rdata));
  lcbwt_ram #(.WIDTH(LEN_W), .DEPTH(HIST_D)) u_hist (
    .clk, .we(h_we), .waddr(h_addr_w), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));

  logic              in_beat, out_beat, first_load;
  logic [LEN_W-1:0]  len_eff, ctx_sum, ctx_addr, idx_inc;
  logic [PASS_W-1:0] ctx_k;
  logic              idx_last;

  assign in_chan.ready  = (state_r == ST_IDLE) && !ov_r;
  assign cfg_chan.ready = 1'b1;
  assign in_beat        = in_chan.valid && in_chan.ready;
  assign out_beat       = out_chan.valid && out_chan.ready;

  assign out_chan.valid     = ov_r;
  assign out_chan.out_byte  = obyte_r;
  assign out_chan.prim_idx  = oprim_r;
  assign out_chan.out_last  = olast_r;
  assign out_chan.out_ready = oready_r;

  assign first_load = (load_cnt_r == '0);
  assign len_eff    = first_load ? limit_len(blen_r) : cur_len_r;
  assign ctx_k      = PASS_W'(cur_len_r[LEN_W-1:2]) + PASS_W'(2);
  assign row_rd     = sel_r ? rb_rdata : ra_rdata;
  // (p + j) mod n, p < n and j < n
  assign ctx_sum    = LEN_W'(row_rd) + LEN_W'(pass_r);
  assign ctx_addr   = (ctx_sum >= cur_len_r) ? ctx_sum - cur_len_r : ctx_sum;
  assign idx_inc    = idx_r + LEN_W'(1);
  assign idx_last   = (idx_inc == cur_len_r);

  always_comb begin
    st_we     = (state_r == ST_IDLE) && in_beat && (in_chan.opcode == OP_LOAD);
    st_waddr  = ADDR_W'(len_eff - LEN_W'(1) - load_cnt_r);
    st_wdata  = in_chan.data_byte;
    st_raddr  = (state_r == ST_FST) ? row_rd : ctx_addr[ADDR_W-1:0];
    row_raddr = (state_r == ST_FRD) ? fetch_cnt_r : idx_r[ADDR_W-1:0];
    ra_we     = 1'b0;
    rb_we     = 1'b0;
    row_waddr = h_rdata[ADDR_W-1:0];
    row_wdata = p_r;
    h_we      = 1'b0;
    h_addr_w  = b_r;
    h_wdata   = h_rdata + LEN_W'(1);
    h_raddr   = (state_r == ST_PRD) ? idx_r[7:0] : st_rdata;
    case (state_r)
      ST_INIT: begin
        ra_we     = 1'b1;
        row_waddr = idx_r[ADDR_W-1:0];
        row_wdata = (idx_r == '0) ? '0 : ADDR_W'(cur_len_r - idx_r);
      end
      ST_CLR: begin
        h_we     = 1'b1;
        h_addr_w = idx_r[7:0];
        h_wdata  = '0;
      end
      ST_CWR: h_we = 1'b1;
      ST_PWR: begin
        h_we     = 1'b1;
        h_addr_w = idx_r[7:0];
        h_wdata  = sum_r;
      end
      ST_SWR: begin
        h_we  = 1'b1;
        ra_we = sel_r;
        rb_we = !sel_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      blen_r      <= 11'd1024;
      cur_len_r   <= limit_len(11'd1024);
      load_cnt_r  <= '0;
      fetch_cnt_r <= '0;
      prim_r      <= '0;
      sorted_r    <= 1'b0;
      sel_r       <= 1'b0;
      pass_r      <= '0;
      idx_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg_chan.valid) blen_r <= cfg_chan.block_len;
      if (out_beat) ov_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_beat && in_chan.opcode == OP_LOAD) begin
            if (first_load) begin
              cur_len_r   <= len_eff;
              sorted_r    <= 1'b0;
              fetch_cnt_r <= '0;
            end
            if (load_cnt_r + LEN_W'(1) >= len_eff) begin
              load_cnt_r <= '0;
              idx_r      <= '0;
              sel_r      <= 1'b0;
              pass_r     <= PASS_W'(1);
              state_r    <= ST_INIT;
            end else begin
              load_cnt_r <= load_cnt_r + LEN_W'(1);
            end
          end else if (in_beat) begin
            if (sorted_r) begin
              state_r <= ST_FRD;
            end else begin
              ov_r     <= 1'b1;
              obyte_r  <= '0;
              oprim_r  <= '0;
              olast_r  <= 1'b0;
              oready_r <= 1'b0;
            end
          end
        end
        ST_INIT: begin
          idx_r <= idx_last ? '0 : idx_inc;
          if (idx_last) state_r <= ST_CLR;
        end
        ST_CLR: begin
          idx_r <= (idx_r[7:0] == 8'hFF) ? '0 : idx_inc;
          if (idx_r[7:0] == 8'hFF) state_r <= ST_CRD;
        end
        ST_CRD: state_r <= ST_CST;
        ST_CST: begin
          p_r     <= row_rd;
          state_r <= ST_CHR;
        end
        ST_CHR: begin
          b_r     <= st_rdata;
          state_r <= ST_CWR;
        end
        ST_CWR: begin
          idx_r   <= idx_last ? '0 : idx_inc;
          sum_r   <= '0;
          state_r <= idx_last ? ST_PRD : ST_CRD;
        end
        ST_PRD: state_r <= ST_PWR;
        ST_PWR: begin
          sum_r   <= sum_r + h_rdata;
          idx_r   <= (idx_r[7:0] == 8'hFF) ? '0 : idx_inc;
          state_r <= (idx_r[7:0] == 8'hFF) ? ST_SRD : ST_PRD;
        end
        ST_SRD: state_r <= ST_SST;
        ST_SST: begin
          p_r     <= row_rd;
          state_r <= ST_SHR;
        end
        ST_SHR: begin
          b_r     <= st_rdata;
          state_r <= ST_SWR;
        end
        ST_SWR: begin
          if (p_r == '0) prim_r <= h_rdata[ADDR_W-1:0];
          if (idx_last) begin
            idx_r <= '0;
            sel_r <= !sel_r;
            if (pass_r == ctx_k) begin
              sorted_r    <= 1'b1;
              fetch_cnt_r <= '0;
              state_r     <= ST_IDLE;
            end else begin
              pass_r  <= pass_r + PASS_W'(1);
              state_r <= ST_CLR;
            end
          end else begin
            idx_r   <= idx_inc;
            state_r <= ST_SRD;
          end
        end
        ST_FRD: state_r <= ST_FST;
        ST_FST: state_r <= ST_FOUT;
        ST_FOUT: begin
          ov_r     <= 1'b1;
          obyte_r  <= st_rdata;
          oprim_r  <= prim_r;
          oready_r <= 1'b1;
          olast_r  <= (LEN_W'(fetch_cnt_r) + LEN_W'(1) == cur_len_r);
          if (LEN_W'(fetch_cnt_r) + LEN_W'(1) == cur_len_r) begin
            fetch_cnt_r <= '0;
            sorted_r    <= 1'b0;
          end else begin
            fetch_cnt_r <= fetch_cnt_r + ADDR_W'(1);
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `LCB_ASSERT_IMP(a_ready_vs_pending, clk, rst_n, in_chan.ready, !ov_r, "ready with result pending")
  `LCB_ASSERT_IMP(a_last_is_ready, clk, rst_n, out_chan.valid && out_chan.out_last, out_chan.out_ready, "last without ready")
  `LCB_ASSERT_NXT(a_fetch_busy, clk, rst_n, in_beat && in_chan.opcode == OP_FETCH, !in_chan.ready, "fetch did not block input")
endmodule
